### hw/rtl/hsv_pkg.sv
// Package for the 8-bit RGB to HSV converter: pipeline sizes, hue offsets,
// the max-channel code and the sideband struct that travels with each pixel.
// No dependencies.
package hsv_pkg;

  // Channel and arithmetic widths
  localparam int HSV_CH_W  = 8;
  localparam int HSV_NUM_W = 2 * HSV_CH_W;

  // Pipeline shape: two prep stages, one divider step per quotient bit, one finish stage
  localparam int HSV_PREP_STAGES = 2;
  localparam int HSV_DIV_STEPS   = HSV_CH_W;
  localparam int HSV_STAGES      = HSV_PREP_STAGES + HSV_DIV_STEPS + 1;

  // Conversion constants
  localparam logic [HSV_CH_W-1:0] HUE_SLOPE    = 8'd43;
  localparam logic [HSV_CH_W-1:0] OFFSET_RED   = 8'd0;
  localparam logic [HSV_CH_W-1:0] OFFSET_GREEN = 8'd85;
  localparam logic [HSV_CH_W-1:0] OFFSET_BLUE  = 8'd171;

  typedef logic [HSV_CH_W-1:0]  pix_t;
  typedef logic [HSV_NUM_W-1:0] num_t;

  // Which channel holds the maximum (red wins ties, then green)
  typedef enum logic [1:0] {
    MAX_RED   = 2'd0,
    MAX_GREEN = 2'd1,
    MAX_BLUE  = 2'd2
  } hsv_max_e;

  // Per-pixel data carried alongside the two divider lanes
  typedef struct packed {
    logic     zero;    // max equals min: hue and saturation forced to zero
    logic     neg;     // hue difference is negative
    hsv_max_e sel;     // channel that holds the maximum
    pix_t     bright;  // largest channel
  } hsv_side_t;

  // Hue offset for the channel that holds the maximum
  function automatic pix_t hue_offset(hsv_max_e sel);
    pix_t off;
    unique case (sel)
      MAX_RED:   off = OFFSET_RED;
      MAX_GREEN: off = OFFSET_GREEN;
      MAX_BLUE:  off = OFFSET_BLUE;
      default:   off = OFFSET_RED;
    endcase
    return off;
  endfunction

endpackage

### hw/rtl/hsv_prep.sv
// Front end of the RGB to HSV converter: max/min search and channel select,
// then span, hue difference and the two dividends. Uses hsv_pkg.
module hsv_prep (
  input  logic                                  clk_i,
  input  logic [hsv_pkg::HSV_PREP_STAGES-1:0]   en_i,
  input  hsv_pkg::pix_t                         red_i,
  input  hsv_pkg::pix_t                         green_i,
  input  hsv_pkg::pix_t                         blue_i,
  output hsv_pkg::num_t                         sat_num_o,
  output hsv_pkg::pix_t                         sat_den_o,
  output hsv_pkg::num_t                         hue_num_o,
  output hsv_pkg::pix_t                         hue_den_o,
  output hsv_pkg::hsv_side_t                    side_o
);
  import hsv_pkg::*;

  pix_t     mx, mn, a, b;
  hsv_max_e sel;

  pix_t     mx_q, mn_q, a_q, b_q;
  hsv_max_e sel_q;

  pix_t      span, mag;
  logic      neg;
  num_t      sat_num_d, hue_num_d;
  num_t      sat_num_q, hue_num_q;
  pix_t      span_q;
  hsv_side_t side_d, side_q;

  // Find max and min, pick the difference pair by the max channel
  always_comb begin
    mx = (red_i > green_i) ? red_i : green_i;
    if (blue_i > mx) mx = blue_i;
    mn = (red_i < green_i) ? red_i : green_i;
    if (blue_i < mn) mn = blue_i;
    priority if (mx == red_i) begin
      sel = MAX_RED;
      a   = green_i;
      b   = blue_i;
    end else if (mx == green_i) begin
      sel = MAX_GREEN;
      a   = blue_i;
      b   = red_i;
    end else begin
      sel = MAX_BLUE;
      a   = red_i;
      b   = green_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mx_q  <= mx;
      mn_q  <= mn;
      a_q   <= a;
      b_q   <= b;
      sel_q <= sel;
    end
  end

  // Form span, signed difference magnitude and the scaled dividends
  always_comb begin
    span      = mx_q - mn_q;
    neg       = (a_q < b_q);
    mag       = neg ? (b_q - a_q) : (a_q - b_q);
    sat_num_d = {span, {HSV_CH_W{1'b0}}} - {{HSV_CH_W{1'b0}}, span};
    hue_num_d = {{HSV_CH_W{1'b0}}, mag} * {{HSV_CH_W{1'b0}}, HUE_SLOPE};
    side_d.zero   = (span == '0);
    side_d.neg    = neg;
    side_d.sel    = sel_q;
    side_d.bright = mx_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sat_num_q <= sat_num_d;
      hue_num_q <= hue_num_d;
      span_q    <= span;
      side_q    <= side_d;
    end
  end

  assign sat_num_o = sat_num_q;
  assign sat_den_o = side_q.bright;
  assign hue_num_o = hue_num_q;
  assign hue_den_o = span_q;
  assign side_o    = side_q;

endmodule

### hw/rtl/hsv_div.sv
// Pipelined restoring divider for the converter: one quotient bit per stage,
// two lanes (saturation and hue) plus the pixel sideband. Uses hsv_pkg.
module hsv_div (
  input  logic                                clk_i,
  input  logic [hsv_pkg::HSV_DIV_STEPS-1:0]   en_i,
  input  hsv_pkg::num_t                       sat_num_i,
  input  hsv_pkg::pix_t                       sat_den_i,
  input  hsv_pkg::num_t                       hue_num_i,
  input  hsv_pkg::pix_t                       hue_den_i,
  input  hsv_pkg::hsv_side_t                  side_i,
  output hsv_pkg::pix_t                       sat_quo_o,
  output hsv_pkg::pix_t                       hue_quo_o,
  output hsv_pkg::hsv_side_t                  side_o
);
  import hsv_pkg::*;

  num_t      sat_rem_q [HSV_DIV_STEPS];
  pix_t      sat_den_q [HSV_DIV_STEPS];
  pix_t      sat_quo_q [HSV_DIV_STEPS];
  num_t      hue_rem_q [HSV_DIV_STEPS];
  pix_t      hue_den_q [HSV_DIV_STEPS];
  pix_t      hue_quo_q [HSV_DIV_STEPS];
  hsv_side_t side_q    [HSV_DIV_STEPS];

  for (genvar k = 0; k < HSV_DIV_STEPS; k++) begin : g_step
    localparam int Sh = HSV_DIV_STEPS - 1 - k;

    num_t      sat_rem, hue_rem, sat_sub, hue_sub;
    pix_t      sat_den, hue_den, sat_quo, hue_quo;
    hsv_side_t side;
    logic      sat_ge, hue_ge;

    // Take the previous step, or the prep outputs at the first step
    if (k == 0) begin : g_first
      assign sat_rem = sat_num_i;
      assign sat_den = sat_den_i;
      assign sat_quo = '0;
      assign hue_rem = hue_num_i;
      assign hue_den = hue_den_i;
      assign hue_quo = '0;
      assign side    = side_i;
    end else begin : g_next
      assign sat_rem = sat_rem_q[k-1];
      assign sat_den = sat_den_q[k-1];
      assign sat_quo = sat_quo_q[k-1];
      assign hue_rem = hue_rem_q[k-1];
      assign hue_den = hue_den_q[k-1];
      assign hue_quo = hue_quo_q[k-1];
      assign side    = side_q[k-1];
    end

    // Try subtracting the shifted divisor and set this quotient bit
    assign sat_sub = {{HSV_CH_W{1'b0}}, sat_den} << Sh;
    assign hue_sub = {{HSV_CH_W{1'b0}}, hue_den} << Sh;
    assign sat_ge  = (sat_rem >= sat_sub);
    assign hue_ge  = (hue_rem >= hue_sub);

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        sat_rem_q[k] <= sat_ge ? (sat_rem - sat_sub) : sat_rem;
        hue_rem_q[k] <= hue_ge ? (hue_rem - hue_sub) : hue_rem;
        sat_den_q[k] <= sat_den;
        hue_den_q[k] <= hue_den;
        sat_quo_q[k] <= sat_quo | (pix_t'(sat_ge) << Sh);
        hue_quo_q[k] <= hue_quo | (pix_t'(hue_ge) << Sh);
        side_q[k]    <= side;
      end
    end
  end

  assign sat_quo_o = sat_quo_q[HSV_DIV_STEPS-1];
  assign hue_quo_o = hue_quo_q[HSV_DIV_STEPS-1];
  assign side_o    = side_q[HSV_DIV_STEPS-1];

endmodule

### hw/rtl/hsv_post.sv
// Finish stage of the converter: apply the hue sign and offset, force grey
// and black pixels, and hold the output beat. Uses hsv_pkg.
module hsv_post (
  input  logic               clk_i,
  input  logic               en_i,
  input  hsv_pkg::pix_t      sat_quo_i,
  input  hsv_pkg::pix_t      hue_quo_i,
  input  hsv_pkg::hsv_side_t side_i,
  output hsv_pkg::pix_t      hue_o,
  output hsv_pkg::pix_t      saturation_o,
  output hsv_pkg::pix_t      brightness_o
);
  import hsv_pkg::*;

  pix_t term, hue_d, sat_d;
  pix_t hue_q, sat_q, bright_q;

  // Add the signed hue term to the channel offset, wrapping at 256
  always_comb begin
    term  = side_i.neg ? (pix_t'(0) - hue_quo_i) : hue_quo_i;
    hue_d = side_i.zero ? '0 : (hue_offset(side_i.sel) + term);
    sat_d = side_i.zero ? '0 : sat_quo_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_q    <= hue_d;
      sat_q    <= sat_d;
      bright_q <= side_i.bright;
    end
  end

  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;

endmodule

### hw/rtl/rgb_to_hsv_8bit.sv
// Top level of the 8-bit RGB to HSV converter: stream handshake, stage
// valid bits and stall control. Uses hsv_pkg, hsv_prep, hsv_div, hsv_post.
//
// Usage:
//   Input beats carry one RGB pixel on s_axis_tdata; output beats carry the
//   matching HSV pixel on m_axis_tdata, in the same order, one per input.
//   A beat moves when tvalid and tready are both high on a rising edge.
//   From input beat to output valid a pixel passes two prep stages
//   (max/min, then span and dividends), eight divider stages that each
//   resolve one quotient bit for saturation and hue, and one finish stage that
//   also serves as the output register.
//   Throughput is one pixel per cycle while the receiver keeps up; the divider is fully pipelined.
//   Every stage has its own valid bit and loads when it is empty or the
//   next stage moves, so bubbles collapse and s_axis_tready stays high
//   while any stage is free.
//   When the receiver stalls, the output holds its beat and the pipeline
//   fills up; s_axis_tready falls once every stage holds a pixel.
//   Reset clears all valid bits; no pixel is in flight afterward.
module rgb_to_hsv_8bit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // hue [7:0], saturation [15:8], brightness [23:16]
);
  import hsv_pkg::*;

  localparam int Last = HSV_STAGES - 1;

  logic [HSV_STAGES-1:0] v_q;
  logic [HSV_STAGES-1:0] v_in;
  logic [HSV_STAGES-1:0] en;
  logic [HSV_STAGES-1:0] nxt_rdy;

  num_t      sat_num, hue_num;
  pix_t      sat_den, hue_den, sat_quo, hue_quo;
  hsv_side_t prep_side, div_side;
  pix_t      hue, saturation, brightness;

  // Load a stage when it is empty or its content moves on
  assign nxt_rdy = {m_axis_tready, en[Last:1]};
  assign en      = ~v_q | nxt_rdy;
  assign v_in    = {v_q[Last-1:0], s_axis_tvalid};

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < HSV_STAGES; k++) begin
        if (en[k]) v_q[k] <= v_in[k];
      end
    end
  end

  hsv_prep u_prep (
    .clk_i     (clk_i),
    .en_i      (en[HSV_PREP_STAGES-1:0]),
    .red_i     (s_axis_tdata[7:0]),
    .green_i   (s_axis_tdata[15:8]),
    .blue_i    (s_axis_tdata[23:16]),
    .sat_num_o (sat_num),
    .sat_den_o (sat_den),
    .hue_num_o (hue_num),
    .hue_den_o (hue_den),
    .side_o    (prep_side)
  );

  hsv_div u_div (
    .clk_i     (clk_i),
    .en_i      (en[HSV_PREP_STAGES+HSV_DIV_STEPS-1:HSV_PREP_STAGES]),
    .sat_num_i (sat_num),
    .sat_den_i (sat_den),
    .hue_num_i (hue_num),
    .hue_den_i (hue_den),
    .side_i    (prep_side),
    .sat_quo_o (sat_quo),
    .hue_quo_o (hue_quo),
    .side_o    (div_side)
  );

  hsv_post u_post (
    .clk_i        (clk_i),
    .en_i         (en[Last]),
    .sat_quo_i    (sat_quo),
    .hue_quo_i    (hue_quo),
    .side_i       (div_side),
    .hue_o        (hue),
    .saturation_o (saturation),
    .brightness_o (brightness)
  );

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[Last];
  assign m_axis_tdata  = {brightness, saturation, hue};

endmodule
